// ===== hdl/dlmp_pkg.sv =====
// Shared types, character codes and report codes for the desk line message parser.
package dlmp_pkg;

    // characters seen on the desk controller line
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_U     = 8'h75;

    // line length saturates here
    localparam int          LEN_W      = 3;
    localparam logic [2:0]  LEN_CAP    = 3'd6;
    localparam logic [2:0]  LEN_BTN    = 3'd2;
    localparam logic [2:0]  LEN_NUM_LO = 3'd4;
    localparam logic [2:0]  LEN_NUM_HI = 3'd5;

    // status colors
    localparam logic [2:0] COLOR_NONE  = 3'd0;
    localparam logic [2:0] COLOR_RED   = 3'd1;
    localparam logic [2:0] COLOR_GREEN = 3'd2;
    localparam logic [2:0] COLOR_WHITE = 3'd3;
    localparam logic [2:0] COLOR_BLUE  = 3'd4;

    // message class handed from front to back
    localparam int         MSG_W     = 3;
    localparam logic [2:0] MSG_LEG_A = 3'd0;
    localparam logic [2:0] MSG_LEG_B = 3'd1;
    localparam logic [2:0] MSG_PRE_H = 3'd2;
    localparam logic [2:0] MSG_PRE_L = 3'd3;
    localparam logic [2:0] MSG_BTN_D = 3'd4;
    localparam logic [2:0] MSG_BTN_U = 3'd5;
    localparam logic [2:0] MSG_BAD   = 3'd6;
    localparam logic [2:0] MSG_ERR   = 3'd7;

    // report kinds
    localparam logic KIND_LINE  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // button bits
    localparam logic [1:0] BTN_DOWN = 2'b01;
    localparam logic [1:0] BTN_UP   = 2'b10;

    // config register indexes (word address)
    localparam logic [1:0] REG_ENCODER_LOW  = 2'd0;
    localparam logic [1:0] REG_HEIGHT_LOW   = 2'd1;
    localparam logic [1:0] REG_HEIGHT_SLOPE = 2'd2;
    localparam logic [23:0] SLOPE_RESET     = 24'd256;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [MSG_W-1:0] msg;
        logic [15:0]      value;
        logic             pressed;
        logic [7:0]       err;
    } t_req;

    typedef struct packed {
        logic [15:0]        encoder_low;
        logic signed [23:0] height_low;
        logic [23:0]        height_slope;
    } t_cfg;

    // report fields that travel unchanged down the height pipeline
    typedef struct packed {
        logic        kind;
        logic        ok;
        logic [2:0]  color;
        logic [1:0]  buttons;
        logic [15:0] leg_a_code;
        logic [15:0] leg_b_code;
        logic [15:0] preset_high_code;
        logic [15:0] preset_low_code;
        logic [7:0]  serial_error;
    } t_snap;

    typedef struct packed {
        t_snap              snap;
        logic signed [23:0] leg_a_height;
        logic signed [23:0] leg_b_height;
        logic signed [23:0] desk_height;
    } t_rep;

endpackage

// ===== hdl/dlmp_front.sv =====
// Front end: gathers line characters and classifies each finished line or error event.
module dlmp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_cmd,
    input  logic [7:0]    i_rx_byte,
    input  logic [7:0]    i_error_code,
    input  logic          i_full,
    output logic          o_push,
    output dlmp_pkg::t_req o_req
);
    import dlmp_pkg::*;

    logic [LEN_W-1:0] r_len;
    logic [7:0]       r_first;
    logic [7:0]       r_second;
    logic [15:0]      r_accum;
    logic             r_stopped;

    logic w_take;
    logic w_nl;
    logic w_digit;
    logic w_num_len;
    logic w_btn_len;
    logic [15:0] w_next_accum;

    assign o_ready = !i_full;
    assign w_take  = i_valid && !i_full;
    assign w_nl    = (i_rx_byte == CH_NL);
    assign w_digit = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    // n*10 + digit, wraps at 16 bits
    assign w_next_accum = (r_accum << 3) + (r_accum << 1) + {8'd0, i_rx_byte - CH_ZERO};

    assign w_num_len = (r_len == LEN_NUM_LO) || (r_len == LEN_NUM_HI);
    assign w_btn_len = (r_len == LEN_BTN);

    assign o_push = w_take && (i_cmd || w_nl);

    always_comb begin
        o_req.value   = r_accum;
        o_req.pressed = (r_second == CH_ONE);
        o_req.err     = i_error_code;
        if (i_cmd) begin
            o_req.msg = MSG_ERR;
        end else if (r_first == CH_A && w_num_len) begin
            o_req.msg = MSG_LEG_A;
        end else if (r_first == CH_B && w_num_len) begin
            o_req.msg = MSG_LEG_B;
        end else if (r_first == CH_H && w_num_len) begin
            o_req.msg = MSG_PRE_H;
        end else if (r_first == CH_L && w_num_len) begin
            o_req.msg = MSG_PRE_L;
        end else if (r_first == CH_D && w_btn_len) begin
            o_req.msg = MSG_BTN_D;
        end else if (r_first == CH_U && w_btn_len) begin
            o_req.msg = MSG_BTN_U;
        end else begin
            o_req.msg = MSG_BAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_first   <= '0;
            r_second  <= '0;
            r_accum   <= '0;
            r_stopped <= 1'b0;
        end else if (w_take && !i_cmd) begin
            if (w_nl) begin
                r_len     <= '0;
                r_first   <= '0;
                r_second  <= '0;
                r_accum   <= '0;
                r_stopped <= 1'b0;
            end else begin
                if (r_len == '0) begin
                    r_first <= i_rx_byte;
                end else begin
                    if (r_len == LEN_W'(1)) begin
                        r_second <= i_rx_byte;
                    end
                    if (!r_stopped) begin
                        if (w_digit) begin
                            r_accum <= w_next_accum;
                        end else begin
                            r_stopped <= 1'b1;
                        end
                    end
                end
                if (r_len < LEN_CAP) begin
                    r_len <= r_len + LEN_W'(1);
                end
            end
        end
    end

endmodule

// ===== hdl/dlmp_queue.sv =====
// Short request queue between the front end and the back end.
module dlmp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dlmp_pkg::t_req i_req,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output dlmp_pkg::t_req o_req
);
    import dlmp_pkg::*;

    t_req             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr;
    logic [Q_AW-1:0]  r_rd;
    logic [Q_CW-1:0]  r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_req   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + Q_CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - Q_CW'(1);
            end
        end
    end

endmodule

// ===== hdl/dlmp_back.sv =====
// Back end: applies line messages to the desk state and computes fixed-point heights.
module dlmp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    output logic           o_pop,
    input  dlmp_pkg::t_req i_req,
    input  dlmp_pkg::t_cfg i_cfg,
    output logic           o_valid,
    input  logic           i_ready,
    output dlmp_pkg::t_rep o_rep
);
    import dlmp_pkg::*;

    function automatic logic signed [23:0] height_fix(
        input logic [15:0]        code,
        input logic signed [41:0] prod,
        input logic signed [23:0] h_low
    );
        logic signed [41:0] q;
        logic signed [41:0] s;
        begin
            q = prod >>> 8;
            s = q + 42'(h_low);
            if (code == '0) begin
                height_fix = '0;
            end else if (s > 42'sd8388607) begin
                height_fix = 24'sh7FFFFF;
            end else if (s < -42'sd8388608) begin
                height_fix = 24'sh800000;
            end else begin
                height_fix = s[23:0];
            end
        end
    endfunction

    // desk state, also the stage-1 snapshot
    logic [15:0] r_leg_a, r_leg_b, r_pre_h, r_pre_l;
    logic [1:0]  r_btn;
    logic [2:0]  r_color;
    logic        r_s1_valid, r_s1_kind, r_s1_ok;
    logic [7:0]  r_s1_err;

    logic [15:0] n_leg_a, n_leg_b, n_pre_h, n_pre_l;
    logic [1:0]  n_btn;
    logic [2:0]  n_color;
    logic        n_ok, n_kind;

    logic               r_s2_valid;
    t_snap              r_s2_snap;
    logic signed [41:0] r_prod_a, r_prod_b;

    logic               r_s3_valid;
    t_snap              r_s3_snap;
    logic signed [23:0] r_ha, r_hb;

    logic  r_out_valid;
    t_rep  r_out;

    logic               w_en;
    t_snap              w_s1_snap;
    logic signed [16:0] w_diff_a, w_diff_b;
    logic signed [24:0] w_slope;
    logic signed [24:0] w_sum;

    assign w_en    = !r_out_valid || i_ready;
    assign o_pop   = w_en && !i_empty;
    assign o_valid = r_out_valid;
    assign o_rep   = r_out;

    // apply one message
    always_comb begin
        n_leg_a = r_leg_a;
        n_leg_b = r_leg_b;
        n_pre_h = r_pre_h;
        n_pre_l = r_pre_l;
        n_btn   = r_btn;
        n_color = r_color;
        n_ok    = 1'b1;
        n_kind  = KIND_LINE;
        unique case (i_req.msg) inside
            MSG_LEG_A: begin
                if (i_req.value != r_leg_a) begin
                    n_leg_a = i_req.value;
                    n_color = (r_btn != '0) ? COLOR_GREEN : COLOR_BLUE;
                end
            end
            MSG_LEG_B: begin
                if (i_req.value != r_leg_b) begin
                    n_leg_b = i_req.value;
                    n_color = (r_btn != '0) ? COLOR_GREEN : COLOR_BLUE;
                end
            end
            MSG_PRE_H: begin
                if (i_req.value != r_pre_h) begin
                    n_pre_h = i_req.value;
                    n_color = COLOR_WHITE;
                end
            end
            MSG_PRE_L: begin
                if (i_req.value != r_pre_l) begin
                    n_pre_l = i_req.value;
                    n_color = COLOR_WHITE;
                end
            end
            MSG_BTN_D, MSG_BTN_U: begin
                if (i_req.pressed) begin
                    n_btn = r_btn | ((i_req.msg == MSG_BTN_D) ? BTN_DOWN : BTN_UP);
                end else begin
                    n_btn = r_btn & ~((i_req.msg == MSG_BTN_D) ? BTN_DOWN : BTN_UP);
                end
                n_color = (n_btn != '0) ? COLOR_GREEN : COLOR_WHITE;
            end
            MSG_ERR: begin
                n_ok    = 1'b0;
                n_kind  = KIND_ERROR;
                n_color = COLOR_RED;
            end
            default: begin
                n_ok    = 1'b0;
                n_color = COLOR_RED;
            end
        endcase
    end

    always_comb begin
        w_s1_snap.kind             = r_s1_kind;
        w_s1_snap.ok               = r_s1_ok;
        w_s1_snap.color            = r_color;
        w_s1_snap.buttons          = r_btn;
        w_s1_snap.leg_a_code       = r_leg_a;
        w_s1_snap.leg_b_code       = r_leg_b;
        w_s1_snap.preset_high_code = r_pre_h;
        w_s1_snap.preset_low_code  = r_pre_l;
        w_s1_snap.serial_error     = r_s1_err;
    end

    assign w_diff_a = $signed({1'b0, r_leg_a}) - $signed({1'b0, i_cfg.encoder_low});
    assign w_diff_b = $signed({1'b0, r_leg_b}) - $signed({1'b0, i_cfg.encoder_low});
    assign w_slope  = $signed({1'b0, i_cfg.height_slope});
    assign w_sum    = {r_ha[23], r_ha} + {r_hb[23], r_hb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leg_a     <= '0;
            r_leg_b     <= '0;
            r_pre_h     <= '0;
            r_pre_l     <= '0;
            r_btn       <= '0;
            r_color     <= COLOR_NONE;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid  <= !i_empty;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
            if (!i_empty) begin
                r_leg_a <= n_leg_a;
                r_leg_b <= n_leg_b;
                r_pre_h <= n_pre_h;
                r_pre_l <= n_pre_l;
                r_btn   <= n_btn;
                r_color <= n_color;
            end
        end
    end

    // payload, moves with the pipeline enable
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!i_empty) begin
                r_s1_kind <= n_kind;
                r_s1_ok   <= n_ok;
                r_s1_err  <= (i_req.msg == MSG_ERR) ? i_req.err : 8'd0;
            end
            r_s2_snap <= w_s1_snap;
            r_prod_a  <= 42'(w_diff_a) * 42'(w_slope);
            r_prod_b  <= 42'(w_diff_b) * 42'(w_slope);
            r_s3_snap <= r_s2_snap;
            r_ha      <= height_fix(r_s2_snap.leg_a_code, r_prod_a, i_cfg.height_low);
            r_hb      <= height_fix(r_s2_snap.leg_b_code, r_prod_b, i_cfg.height_low);
            r_out.snap         <= r_s3_snap;
            r_out.leg_a_height <= r_ha;
            r_out.leg_b_height <= r_hb;
            if (r_s3_snap.leg_a_code == '0 || r_s3_snap.leg_b_code == '0) begin
                r_out.desk_height <= '0;
            end else begin
                r_out.desk_height <= w_sum[24:1];
            end
        end
    end

endmodule

// ===== hdl/desk_line_message_parser.sv =====
// Top level of the desk line message parser: stream ports, config registers, front, queue, back.
//
// Takes one beat per cycle on the slave stream unless stalled: a received character (tuser 0)
// or a serial receive error event (tuser 1). Characters gather into a line; a newline beat and
// an error beat each produce one report beat on the master stream, plain characters produce
// none. A line of 'a'/'b' plus a 3-4 digit number sets the leg A/B encoder code, 'h'/'l' sets
// the high/low preset, 'd'/'u' plus one character sets the down/up button ('1' = pressed); any
// other line, empty ones included, turns the status red and reports line_ok = 0. The number
// stops at the first non-digit and wraps at 16 bits. Leg heights are
// height_low + floor((code - encoder_low) * height_slope / 256), saturated to 24 bits signed,
// and read 0 while the code is 0; desk height is their floored mean, 0 while either code is 0.
// Throughput is one beat per cycle on both sides while no stall holds it. A report passes
// through queue write, state update, multiply, height sum/saturate and average registers.
// A four-entry queue sits between the character front end and the height pipeline, so the
// slave side keeps taking beats while a report waits on the master side; s_axis_tready drops
// only once four reports are queued behind a stalled output. Config registers (APB, word
// addresses 0x0 encoder_low, 0x4 height_low, 0x8 height_slope) are read by the pipeline
// live and are to be written only while no report is in flight.
module desk_line_message_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // [7:0] rx_byte, [15:8] error_code
    input  logic         s_axis_tuser,   // [0] cmd
    // master stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [151:0] m_axis_tdata,   // [0] line_ok, [3:1] status_color, [5:4] buttons,
                                         // [21:6] leg_a_code, [37:22] leg_b_code,
                                         // [61:38] leg_a_height, [85:62] leg_b_height,
                                         // [109:86] desk_height, [125:110] preset_high_code,
                                         // [141:126] preset_low_code, [149:142] serial_error,
                                         // [151:150] zero
    output logic         m_axis_tuser,   // [0] report_kind
    // config port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import dlmp_pkg::*;

    t_cfg  r_cfg;
    logic  w_cfg_wr;
    logic  w_push, w_full, w_pop, w_empty;
    t_req  w_req_in, w_req_out;
    t_rep  w_rep;

    // ---------------- config registers ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.encoder_low  <= '0;
            r_cfg.height_low   <= '0;
            r_cfg.height_slope <= SLOPE_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_ENCODER_LOW:  r_cfg.encoder_low  <= pwdata[15:0];
                REG_HEIGHT_LOW:   r_cfg.height_low   <= pwdata[23:0];
                REG_HEIGHT_SLOPE: r_cfg.height_slope <= pwdata[23:0];
                default: ;  // unmapped word, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ENCODER_LOW:  prdata = {16'd0, r_cfg.encoder_low};
            REG_HEIGHT_LOW:   prdata = {8'd0, r_cfg.height_low};
            REG_HEIGHT_SLOPE: prdata = {8'd0, r_cfg.height_slope};
            default:          prdata = '0;
        endcase
    end

    // ---------------- front end: line gathering and classification ----------------
    dlmp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cmd        (s_axis_tuser),
        .i_rx_byte    (s_axis_tdata[7:0]),
        .i_error_code (s_axis_tdata[15:8]),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_req        (w_req_in)
    );

    // ---------------- request queue ----------------
    dlmp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_req_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_req   (w_req_out)
    );

    // ---------------- back end: desk state and height pipeline ----------------
    dlmp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .i_req   (w_req_out),
        .i_cfg   (r_cfg),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rep   (w_rep)
    );

    // report beat packing
    assign m_axis_tuser = w_rep.snap.kind;
    assign m_axis_tdata = {2'd0,
                           w_rep.snap.serial_error,
                           w_rep.snap.preset_low_code,
                           w_rep.snap.preset_high_code,
                           w_rep.desk_height,
                           w_rep.leg_b_height,
                           w_rep.leg_a_height,
                           w_rep.snap.leg_b_code,
                           w_rep.snap.leg_a_code,
                           w_rep.snap.buttons,
                           w_rep.snap.color,
                           w_rep.snap.ok};

    // ---------------- checks ----------------
    // an error report is never a recognized line and always shows red
    a_err_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_ERROR) |->
            (!m_axis_tdata[0] && m_axis_tdata[3:1] == COLOR_RED))
        else $error("error report without red status or with line_ok set");

    // a line report carries no serial error number
    a_line_noerr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_LINE) |-> (m_axis_tdata[149:142] == 8'd0))
        else $error("line report with nonzero serial_error");

    // desk height is zero while either leg code is unknown
    a_desk_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[21:6] == 16'd0 || m_axis_tdata[37:22] == 16'd0)) |->
            (m_axis_tdata[109:86] == 24'd0))
        else $error("desk height nonzero with an unknown leg");

    // a rejected line turns the status red
    a_bad_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[3:1] == COLOR_RED))
        else $error("unrecognized line without red status");

endmodule

// ===== tb/sv/desk_line_message_parser_tb.sv =====
// Testbench for the desk line message parser: directed lines, then random traffic per phase.
module desk_line_message_parser_tb;
    import dlmp_pkg::*;

    // ------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata  = '0;   // [7:0] rx_byte, [15:8] error_code
    logic         s_axis_tuser  = 1'b0; // [0] cmd
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [151:0] m_axis_tdata;         // [0] line_ok, [3:1] status_color, [5:4] buttons,
                                        // [21:6] leg_a_code, [37:22] leg_b_code,
                                        // [61:38] leg_a_height, [85:62] leg_b_height,
                                        // [109:86] desk_height, [125:110] preset_high_code,
                                        // [141:126] preset_low_code, [149:142] serial_error
    logic         m_axis_tuser;         // [0] report_kind
    logic         psel          = 1'b0;
    logic         penable       = 1'b0;
    logic         pwrite        = 1'b0;
    logic [3:0]   paddr         = '0;
    logic [31:0]  pwdata        = '0;
    logic [31:0]  prdata;
    logic         pready;

    // report pipeline is four deep; give it room before touching registers or ending
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_BEATS   = 56;
    localparam int NUM_PHASES    = 6;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    desk_line_message_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------
    // desk model: line gatherer, stored codes, registers
    // ------------------------------------------------------------------
    typedef struct {
        logic               kind;
        logic               ok;
        logic [2:0]         color;
        logic [1:0]         buttons;
        logic [15:0]        code_a;
        logic [15:0]        code_b;
        logic signed [23:0] hgt_a;
        logic signed [23:0] hgt_b;
        logic signed [23:0] hgt_desk;
        logic [15:0]        pre_high;
        logic [15:0]        pre_low;
        logic [7:0]         serr;
    } t_desk_report;

    logic [2:0]         ln_len;
    logic [7:0]         ln_first;
    logic [7:0]         ln_second;
    logic [15:0]        ln_num;
    logic               ln_num_done;
    logic [15:0]        leg_code [2];    // A, B
    logic [15:0]        preset_code [2]; // high, low
    logic [1:0]         btn_bits;
    logic [2:0]         color_cur;

    logic [15:0]        cfg_enc_low   = '0;
    logic signed [23:0] cfg_hgt_low   = '0;
    logic [23:0]        cfg_slope     = SLOPE_RESET;

    t_desk_report       report_q [$];

    // pinned fields for directed rows whose outcome is obvious
    bit                 pin_armed;
    logic               pin_kind;
    logic               pin_ok;
    logic [2:0]         pin_color;
    logic [7:0]         pin_serr;

    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 beats_sent;
    int                 reports_seen;
    int                 err_reports_seen;
    int                 fail_cnt;

    function automatic void line_clear();
        ln_len      = '0;
        ln_first    = '0;
        ln_second   = '0;
        ln_num      = '0;
        ln_num_done = 1'b0;
    endfunction

    // height = height_low + floor((code - encoder_low) * slope / 256), clamped to 24 bits
    function automatic logic signed [23:0] leg_height(logic [15:0] code);
        longint prod;
        longint h;
        if (code == '0)
            return '0;
        prod = (longint'(code) - longint'(cfg_enc_low)) * longint'(cfg_slope);
        h    = longint'(cfg_hgt_low) + (prod >>> 8);
        if (h > 64'sd8388607)
            h = 64'sd8388607;
        else if (h < -64'sd8388608)
            h = -64'sd8388608;
        return h[23:0];
    endfunction

    function automatic t_desk_report snapshot(logic kind, logic ok, logic [7:0] serr);
        t_desk_report r;
        longint       sum;
        r.kind     = kind;
        r.ok       = ok;
        r.color    = color_cur;
        r.buttons  = btn_bits;
        r.code_a   = leg_code[0];
        r.code_b   = leg_code[1];
        r.hgt_a    = leg_height(leg_code[0]);
        r.hgt_b    = leg_height(leg_code[1]);
        r.hgt_desk = '0;
        if (leg_code[0] != '0 && leg_code[1] != '0) begin
            sum        = longint'(r.hgt_a) + longint'(r.hgt_b);
            r.hgt_desk = 24'(sum >>> 1);  // floor of the mean
        end
        r.pre_high = preset_code[0];
        r.pre_low  = preset_code[1];
        r.serr     = serr;
        return r;
    endfunction

    // decode the gathered line at a newline; returns line_ok
    function automatic logic line_decode();
        logic       num_len;
        logic       btn_len;
        int         idx;
        logic [1:0] bit_sel;
        num_len = (ln_len == LEN_NUM_LO) || (ln_len == LEN_NUM_HI);
        btn_len = (ln_len == LEN_BTN);
        if ((ln_first == CH_A || ln_first == CH_B) && num_len) begin
            idx = (ln_first == CH_A) ? 0 : 1;
            if (ln_num != leg_code[idx]) begin
                leg_code[idx] = ln_num;
                color_cur     = (btn_bits != '0) ? COLOR_GREEN : COLOR_BLUE;
            end
            return 1'b1;
        end
        if ((ln_first == CH_H || ln_first == CH_L) && num_len) begin
            idx = (ln_first == CH_H) ? 0 : 1;
            if (ln_num != preset_code[idx]) begin
                preset_code[idx] = ln_num;
                color_cur        = COLOR_WHITE;
            end
            return 1'b1;
        end
        if ((ln_first == CH_D || ln_first == CH_U) && btn_len) begin
            bit_sel = (ln_first == CH_D) ? BTN_DOWN : BTN_UP;
            if (ln_second == CH_ONE)
                btn_bits = btn_bits | bit_sel;
            else
                btn_bits = btn_bits & ~bit_sel;
            color_cur = (btn_bits != '0) ? COLOR_GREEN : COLOR_WHITE;
            return 1'b1;
        end
        color_cur = COLOR_RED;
        return 1'b0;
    endfunction

    // one accepted beat; returns 1 when it produces a report
    function automatic bit desk_step(logic cmd, logic [7:0] ch, logic [7:0] ecode,
                                     output t_desk_report rpt);
        logic ok;
        if (cmd) begin
            color_cur = COLOR_RED;
            rpt = snapshot(KIND_ERROR, 1'b0, ecode);  // line in progress is kept
            return 1'b1;
        end
        if (ch == CH_NL) begin
            ok  = line_decode();
            rpt = snapshot(KIND_LINE, ok, 8'h00);
            line_clear();
            return 1'b1;
        end
        if (ln_len == '0) begin
            ln_first = ch;
        end else begin
            if (ln_len == 3'd1)
                ln_second = ch;
            // number runs from the second char and stops for good at a non-digit
            if (!ln_num_done) begin
                if (ch >= CH_ZERO && ch <= CH_NINE)
                    ln_num = ln_num * 16'd10 + 16'(ch - CH_ZERO);
                else
                    ln_num_done = 1'b1;
            end
        end
        if (ln_len < LEN_CAP)
            ln_len = ln_len + 3'd1;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // stream driver, config writer
    // ------------------------------------------------------------------
    // called right after a rising edge; returns right after the accepting edge
    task automatic send_beat(logic cmd, logic [7:0] ch, logic [7:0] ecode);
        t_desk_report rpt;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {ecode, ch};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        beats_sent++;
        if (desk_step(cmd, ch, ecode, rpt)) begin
            if (pin_armed) begin
                rpt.kind  = pin_kind;
                rpt.ok    = pin_ok;
                rpt.color = pin_color;
                rpt.serr  = pin_serr;
                pin_armed = 1'b0;
            end
            report_q.push_back(rpt);
        end
    endtask

    // unused half of tdata carries noise
    task automatic send_char(logic [7:0] ch);
        send_beat(1'b0, ch, 8'($urandom));
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENCODER_LOW:  cfg_enc_low = val[15:0];
            REG_HEIGHT_LOW:   cfg_hgt_low = val[23:0];
            REG_HEIGHT_SLOPE: cfg_slope   = val[23:0];
            default: ;
        endcase
    endtask

    task automatic apply_cfg(logic [15:0] enc, logic [23:0] hlow, logic [23:0] slope);
        reg_write(REG_ENCODER_LOW, {16'h0000, enc});
        reg_write(REG_HEIGHT_LOW, {{8{hlow[23]}}, hlow});
        reg_write(REG_HEIGHT_SLOPE, {8'h00, slope});
    endtask

    // wait until every report is back, then let the pipe empty out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (report_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // random message generator
    // ------------------------------------------------------------------
    // digits, mostly 3-4 of them; now and then a wrong count or a stray char
    task automatic send_number();
        int         nd;
        int         v;
        int         cut;
        int         tmp;
        logic [7:0] digs [5];
        nd = ($urandom_range(9) == 0) ? $urandom_range(1, 5) : $urandom_range(3, 4);
        case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = 1234;   // repeats give unchanged-code lines
            2:       v = 9999;
            default: v = $urandom_range(0, 9999);
        endcase
        cut = ($urandom_range(9) == 0) ? $urandom_range(0, nd - 1) : nd;
        tmp = v;
        for (int k = nd - 1; k >= 0; k--) begin
            digs[k] = CH_ZERO + 8'(tmp % 10);
            tmp     = tmp / 10;
        end
        for (int k = 0; k < nd; k++)
            send_char((k == cut) ? 8'($urandom) : digs[k]);
        send_char(CH_NL);
    endtask

    task automatic send_random_message();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 10) begin
            // serial error event, sent between lines
            send_beat(1'b1, 8'($urandom), 8'($urandom));
        end else if (pick < 28) begin
            // noise line; may hold stray newlines of its own
            n = $urandom_range(0, 8);
            repeat (n) send_char(8'($urandom));
            send_char(CH_NL);
        end else begin
            case ($urandom_range(0, 2))
                0: begin
                    send_char($urandom_range(1) ? CH_A : CH_B);
                    if ($urandom_range(19) == 0)
                        send_beat(1'b1, 8'($urandom), 8'($urandom));
                    send_number();
                end
                1: begin
                    send_char($urandom_range(1) ? CH_H : CH_L);
                    send_number();
                end
                default: begin
                    send_char($urandom_range(1) ? CH_D : CH_U);
                    send_char(($urandom_range(3) != 0) ? CH_ONE : 8'($urandom));
                    if ($urandom_range(15) == 0)
                        send_char(8'($urandom));  // too long for a button line
                    send_char(CH_NL);
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // directed lines, walked in order at reset register values
    // ------------------------------------------------------------------
    typedef struct {
        string      text;
        bit         nl;      // end with a newline
        bit         is_err;  // send an error event instead
        logic [7:0] ecode;
        bit         pin;     // kind/ok/color/serial_error typed in below
        logic       ok;
        logic [2:0] color;
    } t_dir_row;

    t_dir_row plan [] = '{
        '{"",       1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, COLOR_RED},   // error right after reset
        '{"",       1'b1, 1'b0, 8'h00, 1'b1, 1'b0, COLOR_RED},   // empty line
        '{"a1234",  1'b1, 1'b0, 8'h00, 1'b1, 1'b1, COLOR_BLUE},
        '{"a1234",  1'b1, 1'b0, 8'h00, 1'b1, 1'b1, COLOR_BLUE},  // same code again
        '{"b0999",  1'b1, 1'b0, 8'h00, 1'b1, 1'b1, COLOR_BLUE},
        '{"d1",     1'b1, 1'b0, 8'h00, 1'b1, 1'b1, COLOR_GREEN},
        '{"a0000",  1'b1, 1'b0, 8'h00, 1'b1, 1'b1, COLOR_GREEN}, // leg A unknown again
        '{"u1",     1'b1, 1'b0, 8'h00, 1'b1, 1'b1, COLOR_GREEN},
        '{"d0",     1'b1, 1'b0, 8'h00, 1'b1, 1'b1, COLOR_GREEN},
        '{"u7",     1'b1, 1'b0, 8'h00, 1'b1, 1'b1, COLOR_WHITE}, // only '1' presses
        '{"h9999",  1'b1, 1'b0, 8'h00, 1'b1, 1'b1, COLOR_WHITE},
        '{"a9999",  1'b1, 1'b0, 8'h00, 1'b1, 1'b1, COLOR_BLUE},
        '{"l000",   1'b1, 1'b0, 8'h00, 1'b1, 1'b1, COLOR_BLUE},  // preset unchanged
        '{"b65535", 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, COLOR_RED},   // six chars: too long
        '{"a12x4",  1'b1, 1'b0, 8'h00, 1'b1, 1'b1, COLOR_BLUE},  // number stops at x
        '{"a 123",  1'b1, 1'b0, 8'h00, 1'b1, 1'b1, COLOR_BLUE},  // space not skipped
        '{"b-12",   1'b1, 1'b0, 8'h00, 1'b0, 1'b0, COLOR_NONE},  // sign not honored
        '{"x",      1'b1, 1'b0, 8'h00, 1'b1, 1'b0, COLOR_RED},
        '{"d",      1'b1, 1'b0, 8'h00, 1'b1, 1'b0, COLOR_RED},
        '{"u10",    1'b1, 1'b0, 8'h00, 1'b1, 1'b0, COLOR_RED},
        '{"a5",     1'b0, 1'b0, 8'h00, 1'b0, 1'b0, COLOR_NONE},  // line left open
        '{"",       1'b0, 1'b1, 8'h00, 1'b1, 1'b0, COLOR_RED},   // error mid-line
        '{"55",     1'b1, 1'b0, 8'h00, 1'b1, 1'b1, COLOR_BLUE},  // finishes "a555"
        '{"\377\200", 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, COLOR_RED}, // high-bit chars
        '{"h0100",  1'b1, 1'b0, 8'h00, 1'b1, 1'b1, COLOR_WHITE}
    };

    task automatic run_row(t_dir_row row);
        for (int i = 0; i < row.text.len(); i++)
            send_char(row.text[i]);
        pin_armed = row.pin;
        pin_kind  = row.is_err ? KIND_ERROR : KIND_LINE;
        pin_ok    = row.ok;
        pin_color = row.color;
        pin_serr  = row.is_err ? row.ecode : 8'h00;
        if (row.is_err)
            send_beat(1'b1, 8'($urandom), row.ecode);
        else if (row.nl)
            send_char(CH_NL);
        pin_armed = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // output side: random stalls and report checking
    // ------------------------------------------------------------------
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic check_field(string fname, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : report_check
        t_desk_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (report_q.size() == 0) begin
                $error("report beat with no report pending");
                fail_cnt++;
            end else begin
                want = report_q.pop_front();
                check_field("report_kind", want.kind, m_axis_tuser);
                check_field("line_ok", want.ok, m_axis_tdata[0]);
                check_field("status_color", want.color, m_axis_tdata[3:1]);
                check_field("buttons", want.buttons, m_axis_tdata[5:4]);
                check_field("leg_a_code", want.code_a, m_axis_tdata[21:6]);
                check_field("leg_b_code", want.code_b, m_axis_tdata[37:22]);
                check_field("leg_a_height", want.hgt_a, $signed(m_axis_tdata[61:38]));
                check_field("leg_b_height", want.hgt_b, $signed(m_axis_tdata[85:62]));
                check_field("desk_height", want.hgt_desk, $signed(m_axis_tdata[109:86]));
                check_field("preset_high_code", want.pre_high, m_axis_tdata[125:110]);
                check_field("preset_low_code", want.pre_low, m_axis_tdata[141:126]);
                check_field("serial_error", want.serr, m_axis_tdata[149:142]);
                reports_seen++;
                if (want.kind == KIND_ERROR)
                    err_reports_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------
    initial begin : run_seq
        int target;
        line_clear();
        leg_code       = '{default: '0};
        preset_code    = '{default: '0};
        btn_bits       = '0;
        color_cur      = COLOR_NONE;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at reset register values, no idling
        foreach (plan[i])
            run_row(plan[i]);
        settle();

        // random part: each phase picks register values and an idling pattern
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin  // far above the low reference: clamps high
                    apply_cfg(16'h0000, 24'h7FFFFF, 24'hFFFFFF);
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1: begin  // far below: clamps low
                    apply_cfg(16'hFFFF, 24'h800000, 24'hFFFFFF);
                    send_idle_pct = 61; recv_stall_pct = 0;
                end
                2: begin  // codes on both sides of encoder_low
                    apply_cfg(16'($urandom_range(0, 9999)), 24'($urandom),
                              24'($urandom_range(0, 1024)));
                    send_idle_pct = 0;  recv_stall_pct = 61;
                end
                3: begin  // flat slope
                    apply_cfg(16'd500, 24'h000000, 24'h000000);
                    send_idle_pct = 34; recv_stall_pct = 34;
                end
                4: begin
                    apply_cfg(16'($urandom), 24'($urandom), 24'($urandom));
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                default: begin  // back to the reset values
                    apply_cfg(16'h0000, 24'h000000, SLOPE_RESET);
                    send_idle_pct = 34; recv_stall_pct = 34;
                end
            endcase
            target = beats_sent + PHASE_BEATS;
            while (beats_sent < target)
                send_random_message();
            settle();
        end

        $display("run covered %0d input beats over %0d register settings and four idle mixes",
                 beats_sent, NUM_PHASES + 1);
        $display("%0d reports checked, %0d of them serial error reports",
                 reports_seen, err_reports_seen);
        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // hang guard: far beyond the slowest legal run
    initial begin
        #400000;
        $display("status: fail");
        $finish;
    end

endmodule
